// File: rtl/ehv_pkg.sv
// ----------------------------------------------------------------------------
// ehv_pkg
// Shared types and constants of the e-book container header validator.
// ----------------------------------------------------------------------------
package ehv_pkg;

	// field widths
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned CODE_W  = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned SIZE_W  = 48;
	localparam int unsigned OFF_W   = 32;
	localparam int unsigned KIND_W  = 16;
	localparam int unsigned TBL_W   = 20;

	// container layout
	localparam logic [LEN_W-1:0] HDR_MIN_LEN  = 32'd78;
	localparam logic [LEN_W-1:0] ENTRY_LEN    = 32'd8;
	localparam int unsigned      ENTRY_SHIFT  = 3;
	localparam logic [TBL_W-1:0] TABLE_PAD    = 20'd2;
	localparam logic [LEN_W-1:0] REC0_MIN_LEN = 32'd16;
	localparam logic [TBL_W-1:0] TABLE_BASE   = TBL_W'(HDR_MIN_LEN) + TABLE_PAD;

	// four-character codes, big endian
	localparam logic [CODE_W-1:0] CODE_BOOK = 32'h424F_4F4B;
	localparam logic [CODE_W-1:0] CODE_MOBI = 32'h4D4F_4249;
	localparam logic [CODE_W-1:0] CODE_TEXT = 32'h5445_5874;
	localparam logic [CODE_W-1:0] CODE_READ = 32'h5245_4164;

	// encryption kinds
	localparam logic [KIND_W-1:0] CRYPT_NONE = 16'd0;
	localparam logic [KIND_W-1:0] CRYPT_OLD  = 16'd1;
	localparam logic [KIND_W-1:0] CRYPT_NEW  = 16'd2;

	// mode codes
	localparam logic [1:0] MODE_HDR = 2'd0;
	localparam logic [1:0] MODE_ENT = 2'd1;
	localparam logic [1:0] MODE_FIN = 2'd2;

	// default depth of the command queue (two or more)
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PARAM   = 2'd1,
		ST_CORRUPT = 2'd2,
		ST_UNSUP   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HDR = 2'd0,
		OP_ENT = 2'd1,
		OP_FIN = 2'd2,
		OP_REJ = 2'd3
	} op_t;

	// classified command, front to back
	typedef struct packed {
		op_t               op;
		status_t           hdr_status; // full verdict of a header word
		logic              local_ok;   // stateless checks of entry / finish passed
		logic              enc;        // finish: encrypted kind
		logic [CNT_W-1:0]  cnt;
		logic [SIZE_W-1:0] fsz;
		logic [TBL_W-1:0]  tend;
		logic [OFF_W-1:0]  off;
	} cmd_t;

endpackage

// File: rtl/ehv_front.sv
// ----------------------------------------------------------------------------
// ehv_front
// Classifies an incoming word and settles every check that needs no state.
// ----------------------------------------------------------------------------
module ehv_front (
	input  logic [1:0]                   mode,
	input  logic                         buffer_missing,
	input  logic [ehv_pkg::LEN_W-1:0]    avail_length,
	input  logic [ehv_pkg::CODE_W-1:0]   type_code,
	input  logic [ehv_pkg::CODE_W-1:0]   creator_code,
	input  logic [ehv_pkg::CNT_W-1:0]    entry_total,
	input  logic [ehv_pkg::SIZE_W-1:0]   whole_size,
	input  logic [ehv_pkg::OFF_W-1:0]    entry_offset,
	input  logic [ehv_pkg::KIND_W-1:0]   crypt_kind,
	output ehv_pkg::cmd_t                cmd
);

	logic [ehv_pkg::TBL_W-1:0] tend;
	logic                      known;
	logic                      kind_ok;
	logic                      kind_enc;

	// end of record table: base + count * entry size
	assign tend = ehv_pkg::TBL_W'({entry_total, {ehv_pkg::ENTRY_SHIFT{1'b0}}})
		+ ehv_pkg::TABLE_BASE;

	assign known = (type_code == ehv_pkg::CODE_BOOK && creator_code == ehv_pkg::CODE_MOBI)
		|| (type_code == ehv_pkg::CODE_TEXT && creator_code == ehv_pkg::CODE_READ);

	// encryption kind class
	always_comb begin
		kind_ok  = 1'b0;
		kind_enc = 1'b0;
		if (crypt_kind == ehv_pkg::CRYPT_NONE) begin
			kind_ok = 1'b1;
		end else if (crypt_kind inside {ehv_pkg::CRYPT_OLD, ehv_pkg::CRYPT_NEW}) begin
			kind_ok  = 1'b1;
			kind_enc = 1'b1;
		end
	end

	// build the command word
	always_comb begin
		cmd            = '0;
		cmd.cnt        = entry_total;
		cmd.fsz        = whole_size;
		cmd.tend       = tend;
		cmd.off        = entry_offset;
		cmd.hdr_status = ehv_pkg::ST_OK;
		if (buffer_missing) begin
			cmd.op = ehv_pkg::OP_REJ;
		end else begin
			case (mode)
				ehv_pkg::MODE_HDR: begin
					cmd.op = ehv_pkg::OP_HDR;
					if (avail_length < ehv_pkg::HDR_MIN_LEN)
						cmd.hdr_status = ehv_pkg::ST_CORRUPT;
					else if (!known)
						cmd.hdr_status = ehv_pkg::ST_UNSUP;
					else if (entry_total == '0)
						cmd.hdr_status = ehv_pkg::ST_CORRUPT;
					else if (ehv_pkg::SIZE_W'(tend) > whole_size)
						cmd.hdr_status = ehv_pkg::ST_CORRUPT;
				end
				ehv_pkg::MODE_ENT: begin
					cmd.op       = ehv_pkg::OP_ENT;
					cmd.local_ok = (avail_length >= ehv_pkg::ENTRY_LEN);
				end
				ehv_pkg::MODE_FIN: begin
					cmd.op       = ehv_pkg::OP_FIN;
					cmd.local_ok = (avail_length >= ehv_pkg::REC0_MIN_LEN) && kind_ok;
					cmd.enc      = kind_enc;
				end
				default: begin
					cmd.op = ehv_pkg::OP_REJ;
				end
			endcase
		end
	end

endmodule

// File: rtl/ehv_queue.sv
// ----------------------------------------------------------------------------
// ehv_queue
// Short command queue between the classifying front and the checking back.
// ----------------------------------------------------------------------------
module ehv_queue #(
	parameter int unsigned DEPTH = ehv_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ehv_pkg::cmd_t push_cmd,
	input  logic          pop,
	output ehv_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ehv_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = slots_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue fill count missed a pop");

endmodule

// File: rtl/ehv_back.sv
// ----------------------------------------------------------------------------
// ehv_back
// Carries out queued commands against the container state; one result
// word per command through an output register.
// ----------------------------------------------------------------------------
module ehv_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ehv_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [1:0]    status,
	output logic          is_encrypted
);

	logic [ehv_pkg::SIZE_W-1:0] size_of_file_q, size_of_file_d;
	logic [ehv_pkg::TBL_W-1:0]  table_limit_q, table_limit_d;
	logic [ehv_pkg::OFF_W-1:0]  last_offset_q, last_offset_d;
	logic [ehv_pkg::OFF_W-1:0]  first_start_q, first_start_d;
	logic [ehv_pkg::OFF_W-1:0]  first_end_q, first_end_d;
	logic [ehv_pkg::CNT_W-1:0]  expected_q, expected_d;
	logic [ehv_pkg::CNT_W-1:0]  seen_q, seen_d;

	logic                       out_valid_q;
	ehv_pkg::status_t           status_q, res_status;
	logic                       enc_q, res_enc;

	logic [ehv_pkg::SIZE_W-1:0] off_ext;
	logic [ehv_pkg::SIZE_W-1:0] rec_end;
	logic [ehv_pkg::SIZE_W-1:0] rec_min;

	// take the next command when the output register is free or draining
	assign pop = !empty && (!out_valid_q || !out_stall);

	assign off_ext = ehv_pkg::SIZE_W'(head.off);
	assign rec_end = (first_end_q != '0) ? ehv_pkg::SIZE_W'(first_end_q) : size_of_file_q;
	assign rec_min = ehv_pkg::SIZE_W'(first_start_q) + ehv_pkg::SIZE_W'(ehv_pkg::REC0_MIN_LEN);

	// command execution
	always_comb begin
		size_of_file_d = size_of_file_q;
		table_limit_d  = table_limit_q;
		last_offset_d  = last_offset_q;
		first_start_d  = first_start_q;
		first_end_d    = first_end_q;
		expected_d     = expected_q;
		seen_d         = seen_q;
		res_status     = ehv_pkg::ST_OK;
		res_enc        = 1'b0;
		case (head.op)
			ehv_pkg::OP_HDR: begin
				res_status = head.hdr_status;
				if (head.hdr_status == ehv_pkg::ST_OK) begin
					size_of_file_d = head.fsz;
					table_limit_d  = head.tend;
					last_offset_d  = '0;
					first_start_d  = '0;
					first_end_d    = '0;
					expected_d     = head.cnt;
					seen_d         = '0;
				end
			end
			ehv_pkg::OP_ENT: begin
				if (!head.local_ok || seen_q >= expected_q
					|| head.off < ehv_pkg::OFF_W'(table_limit_q)
					|| off_ext >= size_of_file_q
					|| (seen_q != '0 && head.off <= last_offset_q)) begin
					res_status = ehv_pkg::ST_CORRUPT;
				end else begin
					if (seen_q == '0)
						first_start_d = head.off;
					else if (seen_q == ehv_pkg::CNT_W'(1))
						first_end_d = head.off;
					last_offset_d = head.off;
					seen_d        = seen_q + 1'b1;
				end
			end
			ehv_pkg::OP_FIN: begin
				if (seen_q != expected_q || rec_end < rec_min || !head.local_ok)
					res_status = ehv_pkg::ST_CORRUPT;
				else
					res_enc = head.enc;
			end
			default: begin
				res_status = ehv_pkg::ST_PARAM;
			end
		endcase
	end

	// container state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_of_file_q <= '0;
			table_limit_q  <= '0;
			last_offset_q  <= '0;
			first_start_q  <= '0;
			first_end_q    <= '0;
			expected_q     <= '0;
			seen_q         <= '0;
		end else if (pop) begin
			size_of_file_q <= size_of_file_d;
			table_limit_q  <= table_limit_d;
			last_offset_q  <= last_offset_d;
			first_start_q  <= first_start_d;
			first_end_q    <= first_end_d;
			expected_q     <= expected_d;
			seen_q         <= seen_d;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= res_status;
			enc_q    <= res_enc;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign is_encrypted = enc_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= expected_q)
		else $error("more entries seen than the header announced");

	a_table_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ehv_pkg::SIZE_W'(table_limit_q) <= size_of_file_q)
		else $error("record table end lies beyond the file");

	a_enc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && enc_q |-> status_q == ehv_pkg::ST_OK)
		else $error("encrypted flag on a failed result");

endmodule

// File: rtl/ebook_container_header_validator_core.sv
// ----------------------------------------------------------------------------
// ebook_container_header_validator_core
// Checks a Palm database e-book container word by word and reports status
// and whether the book is encrypted.
// ----------------------------------------------------------------------------
// Takes one word per clock while the queue is not full and gives one result
// word per input word, in order, through the command queue and the output
// register. The sustained rate of one word per cycle is set by the back end,
// which updates the container state (table end, file size, offsets, entry
// counts) as it executes each word. A queue of QUEUE_DEPTH commands sits
// between the classifying front end and the back end, so input words keep
// being taken while a result waits on out_stall, until the queue is full.
// ----------------------------------------------------------------------------
module ebook_container_header_validator_core #(
	parameter int unsigned QUEUE_DEPTH = ehv_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic                         buffer_missing,
	input  logic [ehv_pkg::LEN_W-1:0]    avail_length,
	input  logic [ehv_pkg::CODE_W-1:0]   type_code,
	input  logic [ehv_pkg::CODE_W-1:0]   creator_code,
	input  logic [ehv_pkg::CNT_W-1:0]    entry_total,
	input  logic [ehv_pkg::SIZE_W-1:0]   whole_size,
	input  logic [ehv_pkg::OFF_W-1:0]    entry_offset,
	input  logic [ehv_pkg::KIND_W-1:0]   crypt_kind,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         is_encrypted
);

	ehv_pkg::cmd_t cmd;
	ehv_pkg::cmd_t head;
	logic          q_empty;
	logic          q_full;
	logic          push;
	logic          pop;

	// classify
	ehv_front u_front (
		.mode           (mode),
		.buffer_missing (buffer_missing),
		.avail_length   (avail_length),
		.type_code      (type_code),
		.creator_code   (creator_code),
		.entry_total    (entry_total),
		.whole_size     (whole_size),
		.entry_offset   (entry_offset),
		.crypt_kind     (crypt_kind),
		.cmd            (cmd)
	);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// command queue
	ehv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// execute
	ehv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.is_encrypted (is_encrypted)
	);

endmodule
